// ----- sv/assert_macros.svh -----
// ------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the orthonormalizer
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GSO_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define GSO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/gso_pkg.sv -----
// ------------------------------------------------------------------------
// gso_pkg
// widths, latencies and vector types of the 3x3 orthonormalizer
// ------------------------------------------------------------------------
package gso_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 24;
  localparam int UNIT_W    = FRAC_W + 2;
  localparam int VEC_W     = 40;
  localparam int DOT_W     = 64;
  localparam int D_W       = 48;
  localparam int MAG_W     = 31;
  localparam int SQ_W      = 2 * MAG_W + 2;
  localparam int ROOT_W    = SQ_W / 2;
  localparam int ROOT_STEPS = SQ_W / 2;
  localparam int QUO_W     = FRAC_W + 1;
  localparam int NUM_W     = ROOT_W + FRAC_W + 1;
  localparam int K_W       = $clog2(ROOT_STEPS);
  localparam int E_MAX     = VEC_W - MAG_W;
  localparam int E_W       = $clog2(E_MAX + 1);

  localparam int NORM_LAT  = 6 + ROOT_STEPS + QUO_W;
  localparam int PROJ_LAT  = 4;
  localparam int TOP_LAT   = 3 * NORM_LAT + 2 * PROJ_LAT + 1;

  typedef logic [2:0][VEC_W-1:0]  vec_t;
  typedef logic [2:0][UNIT_W-1:0] uvec_t;

endpackage

// ----- sv/gso_if.sv -----
// ------------------------------------------------------------------------
// gso channel interfaces
// matrix in and orthonormal matrix out, valid/ready
// ------------------------------------------------------------------------
interface gso_in_if;
  import gso_pkg::*;
  logic valid;
  logic ready;
  logic signed [DATA_W-1:0] in_r0c0;
  logic signed [DATA_W-1:0] in_r0c1;
  logic signed [DATA_W-1:0] in_r0c2;
  logic signed [DATA_W-1:0] in_r1c0;
  logic signed [DATA_W-1:0] in_r1c1;
  logic signed [DATA_W-1:0] in_r1c2;
  logic signed [DATA_W-1:0] in_r2c0;
  logic signed [DATA_W-1:0] in_r2c1;
  logic signed [DATA_W-1:0] in_r2c2;

  modport source (
    output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
           in_r2c0, in_r2c1, in_r2c2,
    input  ready
  );
  modport sink (
    input  valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
           in_r2c0, in_r2c1, in_r2c2,
    output ready
  );
endinterface

interface gso_out_if;
  import gso_pkg::*;
  logic valid;
  logic ready;
  logic signed [DATA_W-1:0] out_r0c0;
  logic signed [DATA_W-1:0] out_r0c1;
  logic signed [DATA_W-1:0] out_r0c2;
  logic signed [DATA_W-1:0] out_r1c0;
  logic signed [DATA_W-1:0] out_r1c1;
  logic signed [DATA_W-1:0] out_r1c2;
  logic signed [DATA_W-1:0] out_r2c0;
  logic signed [DATA_W-1:0] out_r2c1;
  logic signed [DATA_W-1:0] out_r2c2;
  logic                     degenerate;

  modport source (
    output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
           out_r2c0, out_r2c1, out_r2c2, degenerate,
    input  ready
  );
  modport sink (
    input  valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
           out_r2c0, out_r2c1, out_r2c2, degenerate,
    output ready
  );
endinterface

// ----- sv/gso_isqrt.sv -----
// ------------------------------------------------------------------------
// gso_isqrt
// pipelined integer square root, one result bit per stage
// ------------------------------------------------------------------------
module gso_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [gso_pkg::SQ_W-1:0]    sq_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic [gso_pkg::ROOT_W-1:0]  root_o,
  output logic [SIDE_W-1:0]           side_o
);
  import gso_pkg::*;

  logic [SQ_W-1:0]   rem_q  [ROOT_STEPS];
  logic [SQ_W-1:0]   res_q  [ROOT_STEPS];
  logic [SIDE_W-1:0] side_q [ROOT_STEPS];
  logic [SQ_W-1:0]   rem_d  [ROOT_STEPS];
  logic [SQ_W-1:0]   res_d  [ROOT_STEPS];
  logic [SIDE_W-1:0] side_d [ROOT_STEPS];

  always_comb begin
    logic [SQ_W-1:0] rin;
    logic [SQ_W-1:0] sin;
    logic [SQ_W-1:0] bitv;
    logic [SQ_W-1:0] trial;
    for (int j = 0; j < ROOT_STEPS; j++) begin
      rin   = (j == 0) ? sq_i : rem_q[(j == 0) ? 0 : j - 1];
      sin   = (j == 0) ? '0 : res_q[(j == 0) ? 0 : j - 1];
      bitv  = SQ_W'(1) << (SQ_W - 2 - 2 * j);
      trial = sin + bitv;
      if (rin >= trial) begin
        rem_d[j] = rin - trial;
        res_d[j] = (sin >> 1) + bitv;
      end else begin
        rem_d[j] = rin;
        res_d[j] = sin >> 1;
      end
      side_d[j] = (j == 0) ? side_i : side_q[(j == 0) ? 0 : j - 1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      res_q  <= res_d;
      side_q <= side_d;
    end
  end

  assign root_o = res_q[ROOT_STEPS-1][ROOT_W-1:0];
  assign side_o = side_q[ROOT_STEPS-1];

endmodule

// ----- sv/gso_div.sv -----
// ------------------------------------------------------------------------
// gso_div
// pipelined restoring divider lane, one quotient bit per stage
// ------------------------------------------------------------------------
module gso_div #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [gso_pkg::NUM_W-1:0]   num_i,
  input  logic [gso_pkg::ROOT_W-1:0]  den_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic [gso_pkg::QUO_W-1:0]   quo_o,
  output logic [SIDE_W-1:0]           side_o
);
  import gso_pkg::*;

  logic [NUM_W-1:0]  rem_q  [QUO_W];
  logic [ROOT_W-1:0] den_q  [QUO_W];
  logic [QUO_W-1:0]  quo_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];
  logic [NUM_W-1:0]  rem_d  [QUO_W];
  logic [ROOT_W-1:0] den_d  [QUO_W];
  logic [QUO_W-1:0]  quo_d  [QUO_W];
  logic [SIDE_W-1:0] side_d [QUO_W];

  always_comb begin
    logic [NUM_W-1:0]  rin;
    logic [ROOT_W-1:0] din;
    logic [QUO_W-1:0]  qin;
    logic [NUM_W-1:0]  trial;
    for (int j = 0; j < QUO_W; j++) begin
      rin   = (j == 0) ? num_i : rem_q[(j == 0) ? 0 : j - 1];
      din   = (j == 0) ? den_i : den_q[(j == 0) ? 0 : j - 1];
      qin   = (j == 0) ? '0 : quo_q[(j == 0) ? 0 : j - 1];
      // divisor aligned to the quotient bit of this stage
      trial = NUM_W'(din) << (QUO_W - 1 - j);
      if (rin >= trial) begin
        rem_d[j] = rin - trial;
        quo_d[j] = qin | (QUO_W'(1) << (QUO_W - 1 - j));
      end else begin
        rem_d[j] = rin;
        quo_d[j] = qin;
      end
      den_d[j]  = din;
      side_d[j] = (j == 0) ? side_i : side_q[(j == 0) ? 0 : j - 1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      den_q  <= den_d;
      quo_q  <= quo_d;
      side_q <= side_d;
    end
  end

  assign quo_o  = quo_q[QUO_W-1];
  assign side_o = side_q[QUO_W-1];

endmodule

// ----- sv/gso_norm.sv -----
// ------------------------------------------------------------------------
// gso_norm
// scales a three-component vector to unit length, three divider lanes
// ------------------------------------------------------------------------
module gso_norm #(
  parameter int SIDE_W = 1
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  gso_pkg::vec_t         vec_i,
  input  logic [SIDE_W-1:0]     side_i,
  output gso_pkg::uvec_t        unit_o,
  output logic                  zero_o,
  output logic [SIDE_W-1:0]     side_o
);
  import gso_pkg::*;

  localparam int SQRT_SIDE_W = 3 * ROOT_W + 4 + SIDE_W;

  // stage 1: magnitudes and common right shift
  logic [VEC_W-1:0]  mag1_q [3];
  logic [2:0]        neg1_q;
  logic [E_W-1:0]    e1_q;
  logic [SIDE_W-1:0] side1_q;
  // stage 2: squares
  logic [MAG_W-1:0]   ms2_q [3];
  logic [2*MAG_W-1:0] sq2_q [3];
  logic [2:0]         neg2_q;
  logic [SIDE_W-1:0]  side2_q;
  // stage 3: square sum
  logic [SQ_W-1:0]   s3_q;
  logic              zero3_q;
  logic [MAG_W-1:0]  ms3_q [3];
  logic [2:0]        neg3_q;
  logic [SIDE_W-1:0] side3_q;
  // stage 4: even left shift amount
  logic [K_W-1:0]    k4_q;
  logic [SQ_W-1:0]   s4_q;
  logic              zero4_q;
  logic [MAG_W-1:0]  ms4_q [3];
  logic [2:0]        neg4_q;
  logic [SIDE_W-1:0] side4_q;
  // stage 5: shifted sum and components
  logic [SQ_W-1:0]   s5_q;
  logic [ROOT_W-1:0] a5_q [3];
  logic              zero5_q;
  logic [2:0]        neg5_q;
  logic [SIDE_W-1:0] side5_q;
  // after root: numerators
  logic [NUM_W-1:0]  num6_q [3];
  logic [ROOT_W-1:0] den6_q;
  logic              zero6_q;
  logic [2:0]        neg6_q;
  logic [SIDE_W-1:0] side6_q;

  logic [VEC_W-1:0]       mag_d [3];
  logic [E_W-1:0]         e_d;
  logic [K_W-1:0]         k_d;
  logic [ROOT_W-1:0]      root;
  logic [SQRT_SIDE_W-1:0] sqrt_side;
  logic [ROOT_W-1:0]      a_r [3];
  logic                   zero_r;
  logic [2:0]             neg_r;
  logic [SIDE_W-1:0]      side_r;
  logic [QUO_W-1:0]       quo [3];
  logic [SIDE_W+1:0]      lane0_side;
  logic                   neg_l1;
  logic                   neg_l2;

  always_comb begin
    logic [VEC_W-1:0] mx;
    mx = '0;
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = vec_i[i][VEC_W-1] ? (~vec_i[i] + 1'b1) : vec_i[i];
      if (mag_d[i] > mx) mx = mag_d[i];
    end
    // smallest shift that brings every magnitude below 2^MAG_W
    e_d = E_W'(E_MAX);
    for (int j = E_MAX; j >= 0; j--) begin
      if (((mx >> j) >> MAG_W) == '0) e_d = E_W'(j);
    end
  end

  always_comb begin
    k_d = '0;
    for (int j = ROOT_STEPS - 1; j >= 0; j--) begin
      if (s3_q[SQ_W-1-2*j] || s3_q[SQ_W-2-2*j]) k_d = K_W'(j);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        mag1_q[i] <= mag_d[i];
        neg1_q[i] <= vec_i[i][VEC_W-1];
        ms2_q[i]  <= MAG_W'(mag1_q[i] >> e1_q);
        sq2_q[i]  <= MAG_W'(mag1_q[i] >> e1_q) * MAG_W'(mag1_q[i] >> e1_q);
        ms3_q[i]  <= ms2_q[i];
        ms4_q[i]  <= ms3_q[i];
        a5_q[i]   <= ROOT_W'(ms4_q[i]) << k4_q;
        num6_q[i] <= (NUM_W'(a_r[i]) << FRAC_W) + NUM_W'(root >> 1);
      end
      e1_q    <= e_d;
      side1_q <= side_i;
      neg2_q  <= neg1_q;
      side2_q <= side1_q;
      s3_q    <= SQ_W'(sq2_q[0]) + SQ_W'(sq2_q[1]) + SQ_W'(sq2_q[2]);
      zero3_q <= (sq2_q[0] == '0) && (sq2_q[1] == '0) && (sq2_q[2] == '0);
      neg3_q  <= neg2_q;
      side3_q <= side2_q;
      k4_q    <= k_d;
      s4_q    <= s3_q;
      zero4_q <= zero3_q;
      neg4_q  <= neg3_q;
      side4_q <= side3_q;
      s5_q    <= s4_q << {k4_q, 1'b0};
      zero5_q <= zero4_q;
      neg5_q  <= neg4_q;
      side5_q <= side4_q;
      den6_q  <= root;
      zero6_q <= zero_r;
      neg6_q  <= neg_r;
      side6_q <= side_r;
    end
  end

  gso_isqrt #(.SIDE_W(SQRT_SIDE_W)) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .sq_i   (s5_q),
    .side_i ({a5_q[0], a5_q[1], a5_q[2], neg5_q, zero5_q, side5_q}),
    .root_o (root),
    .side_o (sqrt_side)
  );

  assign {a_r[0], a_r[1], a_r[2], neg_r, zero_r, side_r} = sqrt_side;

  gso_div #(.SIDE_W(SIDE_W + 2)) u_div0 (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .num_i  (num6_q[0]),
    .den_i  (den6_q),
    .side_i ({neg6_q[0], zero6_q, side6_q}),
    .quo_o  (quo[0]),
    .side_o (lane0_side)
  );

  gso_div #(.SIDE_W(1)) u_div1 (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .num_i  (num6_q[1]),
    .den_i  (den6_q),
    .side_i (neg6_q[1]),
    .quo_o  (quo[1]),
    .side_o (neg_l1)
  );

  gso_div #(.SIDE_W(1)) u_div2 (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .num_i  (num6_q[2]),
    .den_i  (den6_q),
    .side_i (neg6_q[2]),
    .quo_o  (quo[2]),
    .side_o (neg_l2)
  );

  // merge: apply signs, zero column gives zeros
  always_comb begin
    logic [2:0] neg;
    neg = {neg_l2, neg_l1, lane0_side[SIDE_W+1]};
    for (int i = 0; i < 3; i++) begin
      if (lane0_side[SIDE_W]) begin
        unit_o[i] = '0;
      end else if (neg[i]) begin
        unit_o[i] = -UNIT_W'(quo[i]);
      end else begin
        unit_o[i] = UNIT_W'(quo[i]);
      end
    end
  end

  assign zero_o = lane0_side[SIDE_W];
  assign side_o = lane0_side[SIDE_W-1:0];

endmodule

// ----- sv/gso_proj.sv -----
// ------------------------------------------------------------------------
// gso_proj
// removes projections on two unit vectors from a vector
// ------------------------------------------------------------------------
module gso_proj #(
  parameter int SIDE_W = 1
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  gso_pkg::uvec_t        ua_i,
  input  gso_pkg::uvec_t        ub_i,
  input  gso_pkg::vec_t         vec_i,
  input  logic [SIDE_W-1:0]     side_i,
  output gso_pkg::vec_t         res_o,
  output logic [SIDE_W-1:0]     side_o
);
  import gso_pkg::*;

  function automatic logic signed [DOT_W-1:0] rnd_frac(input logic signed [DOT_W-1:0] x);
    logic signed [DOT_W-1:0] t;
    t = x + $signed(DOT_W'(1) << (FRAC_W - 1));
    return t >>> FRAC_W;
  endfunction

  logic signed [DOT_W-1:0] pa_q [3];
  logic signed [DOT_W-1:0] pb_q [3];
  uvec_t                   ua1_q, ub1_q, ua2_q, ub2_q;
  vec_t                    vec1_q, vec2_q, vec3_q;
  logic [SIDE_W-1:0]       side1_q, side2_q, side3_q, side4_q;
  logic signed [D_W-1:0]   da_q, db_q;
  logic signed [DOT_W-1:0] qa_q [3];
  logic signed [DOT_W-1:0] qb_q [3];
  vec_t                    res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        pa_q[i] <= $signed(ua_i[i]) * $signed(vec_i[i]);
        pb_q[i] <= $signed(ub_i[i]) * $signed(vec_i[i]);
        qa_q[i] <= da_q * $signed(ua2_q[i]);
        qb_q[i] <= db_q * $signed(ub2_q[i]);
        res_q[i] <= VEC_W'(DOT_W'($signed(vec3_q[i])) - rnd_frac(qa_q[i] + qb_q[i]));
      end
      ua1_q   <= ua_i;
      ub1_q   <= ub_i;
      vec1_q  <= vec_i;
      side1_q <= side_i;
      da_q    <= D_W'(rnd_frac(pa_q[0] + pa_q[1] + pa_q[2]));
      db_q    <= D_W'(rnd_frac(pb_q[0] + pb_q[1] + pb_q[2]));
      ua2_q   <= ua1_q;
      ub2_q   <= ub1_q;
      vec2_q  <= vec1_q;
      side2_q <= side1_q;
      vec3_q  <= vec2_q;
      side3_q <= side2_q;
      side4_q <= side3_q;
    end
  end

  assign res_o  = res_q;
  assign side_o = side4_q;

endmodule

// ----- sv/gram_schmidt_orthonormalize_3x3_top.sv -----
// ------------------------------------------------------------------------
// gram_schmidt_orthonormalize_3x3_top
// 3x3 orthonormalizer, Q8.24, column by column
//
// channel   dir  word
// in_ch_i   in   nine signed Q8.24 entries, row-major
// out_ch_o  out  nine orthonormal entries and the degenerate flag
//
// one word per cycle sustained while the output is taken; each word runs
// through three normalizers (32-stage root, 25-stage dividers) in series
// all stages advance together; a waiting result stalls the whole pipe
// reset clears only the valid pipe, no clearing pass
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module gram_schmidt_orthonormalize_3x3_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  gso_in_if.sink      in_ch_i,
  gso_out_if.source   out_ch_o
);
  import gso_pkg::*;

  typedef struct packed {
    vec_t b;
    vec_t c;
  } n0_side_t;

  typedef struct packed {
    uvec_t u0;
    vec_t  c;
    logic  deg;
  } n1_side_t;

  typedef struct packed {
    uvec_t u0;
    uvec_t u1;
    logic  deg;
  } n2_side_t;

  localparam logic signed [DATA_W-1:0] UnitOne = DATA_W'(1) << FRAC_W;

  logic [TOP_LAT-1:0] vld_q;
  logic               adv;
  logic               acc;

  vec_t     col_a, col_b, col_c;
  n0_side_t n0_in, n0_out;
  n1_side_t p0_in, p0_out, n1_out;
  n2_side_t p1_in, p1_out, n2_out;
  uvec_t    u0, u1, u2, zero_u;
  vec_t     b_res, c_res;
  logic     z0, z1, z2;

  logic signed [DATA_W-1:0] out_q [9];
  logic                     deg_q;

  assign adv = !vld_q[TOP_LAT-1] || out_ch_o.ready;
  assign acc = in_ch_i.valid && adv;
  assign in_ch_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[TOP_LAT-2:0], in_ch_i.valid};
    end
  end

  assign col_a = {VEC_W'(in_ch_i.in_r2c0), VEC_W'(in_ch_i.in_r1c0), VEC_W'(in_ch_i.in_r0c0)};
  assign col_b = {VEC_W'(in_ch_i.in_r2c1), VEC_W'(in_ch_i.in_r1c1), VEC_W'(in_ch_i.in_r0c1)};
  assign col_c = {VEC_W'(in_ch_i.in_r2c2), VEC_W'(in_ch_i.in_r1c2), VEC_W'(in_ch_i.in_r0c2)};
  assign zero_u = '0;

  assign n0_in = '{b: col_b, c: col_c};

  gso_norm #(.SIDE_W($bits(n0_side_t))) u_norm0 (
    .clk_i  (clk_i),
    .en_i   (adv),
    .vec_i  (col_a),
    .side_i (n0_in),
    .unit_o (u0),
    .zero_o (z0),
    .side_o (n0_out)
  );

  assign p0_in = '{u0: u0, c: n0_out.c, deg: z0};

  gso_proj #(.SIDE_W($bits(n1_side_t))) u_proj0 (
    .clk_i  (clk_i),
    .en_i   (adv),
    .ua_i   (u0),
    .ub_i   (zero_u),
    .vec_i  (n0_out.b),
    .side_i (p0_in),
    .res_o  (b_res),
    .side_o (p0_out)
  );

  gso_norm #(.SIDE_W($bits(n1_side_t))) u_norm1 (
    .clk_i  (clk_i),
    .en_i   (adv),
    .vec_i  (b_res),
    .side_i (p0_out),
    .unit_o (u1),
    .zero_o (z1),
    .side_o (n1_out)
  );

  assign p1_in = '{u0: n1_out.u0, u1: u1, deg: n1_out.deg | z1};

  gso_proj #(.SIDE_W($bits(n2_side_t))) u_proj1 (
    .clk_i  (clk_i),
    .en_i   (adv),
    .ua_i   (n1_out.u0),
    .ub_i   (u1),
    .vec_i  (n1_out.c),
    .side_i (p1_in),
    .res_o  (c_res),
    .side_o (p1_out)
  );

  gso_norm #(.SIDE_W($bits(n2_side_t))) u_norm2 (
    .clk_i  (clk_i),
    .en_i   (adv),
    .vec_i  (c_res),
    .side_i (p1_out),
    .unit_o (u2),
    .zero_o (z2),
    .side_o (n2_out)
  );

  // output word register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        out_q[3*i]   <= DATA_W'($signed(n2_out.u0[i]));
        out_q[3*i+1] <= DATA_W'($signed(n2_out.u1[i]));
        out_q[3*i+2] <= DATA_W'($signed(u2[i]));
      end
      deg_q <= n2_out.deg | z2;
    end
  end

  assign out_ch_o.valid      = vld_q[TOP_LAT-1];
  assign out_ch_o.out_r0c0   = out_q[0];
  assign out_ch_o.out_r0c1   = out_q[1];
  assign out_ch_o.out_r0c2   = out_q[2];
  assign out_ch_o.out_r1c0   = out_q[3];
  assign out_ch_o.out_r1c1   = out_q[4];
  assign out_ch_o.out_r1c2   = out_q[5];
  assign out_ch_o.out_r2c0   = out_q[6];
  assign out_ch_o.out_r2c1   = out_q[7];
  assign out_ch_o.out_r2c2   = out_q[8];
  assign out_ch_o.degenerate = deg_q;

  `GSO_ASSERT_NEXT(a_stall_holds_pipe, clk_i, rst_ni, !adv, $stable(vld_q))
  `GSO_ASSERT_NEXT(a_accept_enters_pipe, clk_i, rst_ni, acc, vld_q[0])
  `GSO_ASSERT(a_unit_range, clk_i, rst_ni, vld_q[TOP_LAT-1], (out_q[0] <= UnitOne) && (out_q[0] >= -UnitOne) && (out_q[4] <= UnitOne) && (out_q[4] >= -UnitOne) && (out_q[8] <= UnitOne) && (out_q[8] >= -UnitOne))

endmodule

// ----- bench/gram_schmidt_orthonormalize_3x3_top_test.sv -----
// ------------------------------------------------------------------------
// gram_schmidt_orthonormalize_3x3_top_test
// self-checking bench for the 3x3 Q8.24 orthonormalizer
//
// a short table of hand-picked matrices, then random matrices of several
// shapes; every accepted word with no typed result is fed to a bit-exact
// predictor; the result queue is checked in order under varied valid/ready idling
// ------------------------------------------------------------------------
module gram_schmidt_orthonormalize_3x3_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gso_pkg::*;

  typedef logic [8:0][DATA_W-1:0] mat_t;   // index row*3+col
  typedef struct packed {
    mat_t q;
    logic degen;
  } ortho_t;
  typedef struct {
    mat_t   m;
    logic   typed;
    ortho_t want;
  } row_t;
  typedef longint trip_t[3];

  localparam longint ONE = 64'sd1 <<< FRAC_W;
  localparam int HOLD_CYCLES = 800;
  localparam int STALL_LIMIT = 6000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  gso_in_if  in_ch();
  gso_out_if out_ch();

  gram_schmidt_orthonormalize_3x3_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch_i(in_ch.sink), .out_ch_o(out_ch.source)
  );

  row_t   pending_words[$];
  ortho_t expected_q[$];
  int     mismatches = 0;
  int     words_in = 0, words_out = 0, degen_seen = 0;
  int     idle_in_pct = 0, stall_out_pct = 0;
  logic   hold_request = 1'b0, hold_done = 1'b0;
  int     hold_left = 0;
  int     quiet_cycles = 0;

  // ---------------- predictor ----------------
  function automatic longint round_frac(longint v);
    longint x;
    x = v + (64'sd1 <<< (FRAC_W - 1));
    return x >>> FRAC_W;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // returns 1 when the column is all zero
  function automatic logic unit_column(input trip_t v, output trip_t u);
    longint unsigned m[3], mx, s, r, a, q;
    int e, k;
    e = 0;
    k = 0;
    for (int i = 0; i < 3; i++) m[i] = v[i] < 0 ? -v[i] : v[i];
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    while ((mx >> e) >= 64'd2147483648) e++;
    for (int i = 0; i < 3; i++) m[i] >>= e;
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    if (s == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return 1'b1;
    end
    while ((s >> 62) == 0) begin
      s <<= 2;
      k++;
    end
    r = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      a = m[i] << k;
      q = ((a << FRAC_W) + (r >> 1)) / r;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b0;
  endfunction

  function automatic ortho_t orthonormalize(mat_t m);
    trip_t a, b, c, u0, u1, u2;
    longint d0, d1, d2;
    ortho_t o;
    o.degen = 1'b0;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(m[i*3+0]));
      b[i] = longint'($signed(m[i*3+1]));
      c[i] = longint'($signed(m[i*3+2]));
    end
    o.degen |= unit_column(a, u0);
    d0 = round_frac(u0[0]*b[0] + u0[1]*b[1] + u0[2]*b[2]);
    for (int i = 0; i < 3; i++) b[i] = b[i] - round_frac(d0 * u0[i]);
    o.degen |= unit_column(b, u1);
    // both projections measured against the original third column
    d1 = round_frac(u0[0]*c[0] + u0[1]*c[1] + u0[2]*c[2]);
    d2 = round_frac(u1[0]*c[0] + u1[1]*c[1] + u1[2]*c[2]);
    for (int i = 0; i < 3; i++) c[i] = c[i] - round_frac(d1 * u0[i] + d2 * u1[i]);
    o.degen |= unit_column(c, u2);
    for (int i = 0; i < 3; i++) begin
      o.q[i*3+0] = u0[i][DATA_W-1:0];
      o.q[i*3+1] = u1[i][DATA_W-1:0];
      o.q[i*3+2] = u2[i][DATA_W-1:0];
    end
    return o;
  endfunction

  // ---------------- stimulus shapes ----------------
  function automatic mat_t random_matrix(int shape);
    mat_t m;
    int zc;
    for (int i = 0; i < 9; i++) m[i] = $urandom;
    case (shape)
      1: for (int i = 0; i < 9; i++) m[i] = $signed($urandom) >>> $urandom_range(0, 28);
      2: begin
        zc = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) m[i*3+zc] = '0;
      end
      3: for (int i = 0; i < 3; i++) begin   // later columns copy earlier ones row by row, up to sign
        m[i*3+1] = $urandom_range(0, 1) ? m[i*3+0] : -m[i*3+0];
        if ($urandom_range(0, 1)) m[i*3+2] = m[i*3+1];
      end
      4: for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? ONE[31:0] + $urandom_range(0, 255)
                                                       : $urandom_range(0, 511) - 256;
      default: ;
    endcase
    return m;
  endfunction

  function automatic row_t table_row(mat_t m, logic typed, ortho_t want);
    row_t r;
    r.m = m;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // ---------------- sender ----------------
  initial begin
    in_ch.valid = 1'b0;
    {in_ch.in_r0c0, in_ch.in_r0c1, in_ch.in_r0c2, in_ch.in_r1c0, in_ch.in_r1c1,
     in_ch.in_r1c2, in_ch.in_r2c0, in_ch.in_r2c1, in_ch.in_r2c2} = '0;
    out_ch.ready = 1'b0;
  end

  row_t on_bus;

  always @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      expected_q.push_back(on_bus.typed ? on_bus.want : orthonormalize(on_bus.m));
      words_in++;
    end
    if (rst_ni && (!in_ch.valid || in_ch.ready)) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_in_pct) begin
        on_bus <= pending_words[0];
        {in_ch.in_r2c2, in_ch.in_r2c1, in_ch.in_r2c0, in_ch.in_r1c2, in_ch.in_r1c1,
         in_ch.in_r1c0, in_ch.in_r0c2, in_ch.in_r0c1, in_ch.in_r0c0} <= pending_words[0].m;
        void'(pending_words.pop_front());
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------- receiver ----------------
  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_request && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  task automatic report(string what, int idx, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("mismatch word %0d field %0d %s: got %h want %h", words_out, idx, what, got,
             want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    mat_t got;
    ortho_t want;
    if (out_ch.valid && out_ch.ready) begin
      got = {out_ch.out_r2c2, out_ch.out_r2c1, out_ch.out_r2c0, out_ch.out_r1c2,
             out_ch.out_r1c1, out_ch.out_r1c0, out_ch.out_r0c2, out_ch.out_r0c1,
             out_ch.out_r0c0};
      if (expected_q.size() == 0) begin
        report("unexpected word", 10, '0, '0);
      end else begin
        want = expected_q.pop_front();
        for (int i = 0; i < 9; i++)
          if (got[i] !== want.q[i]) report($sformatf("r%0dc%0d", i / 3, i % 3), i, got[i], want.q[i]);
        if (out_ch.degenerate !== want.degen)
          report("degenerate", 9, out_ch.degenerate, want.degen);
        degen_seen += want.degen;
      end
      words_out++;
    end
    if (rst_ni)
      out_ch.ready <= (hold_left > 1) ? 1'b0 : ($urandom_range(0, 99) >= stall_out_pct);
  end

  // ---------------- watchdog ----------------
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  initial begin
    mat_t m;
    ortho_t none, zero_res, ident_res;
    none = '0;
    zero_res = '0;
    zero_res.degen = 1'b1;
    ident_res = '0;
    ident_res.q[0] = ONE[31:0];
    ident_res.q[4] = ONE[31:0];
    ident_res.q[8] = ONE[31:0];

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    pending_words.push_back(table_row('0, 1'b1, zero_res));
    pending_words.push_back(table_row(ident_res.q, 1'b1, ident_res));
    m = '0;
    for (int i = 0; i < 9; i++) m[i] = 32'h7fffffff;
    pending_words.push_back(table_row(m, 1'b0, none));
    for (int i = 0; i < 9; i++) m[i] = 32'h80000000;
    pending_words.push_back(table_row(m, 1'b0, none));
    m = '0;
    m[0] = 32'h80000000; m[4] = 32'h80000000; m[8] = 32'h80000000;
    pending_words.push_back(table_row(m, 1'b0, none));
    m = '0;
    m[0] = 32'h7fffffff; m[4] = 32'h80000000; m[8] = 32'h00000001;
    pending_words.push_back(table_row(m, 1'b0, none));
    m = '0;
    m[0] = 32'h00000001; m[1] = 32'hffffffff; m[5] = 32'h7fffffff; m[7] = 32'h80000000;
    pending_words.push_back(table_row(m, 1'b0, none));
    for (int i = 0; i < 9; i++) m[i] = ((i % 3) == 1) ? 32'h0 : 32'h01000000;
    pending_words.push_back(table_row(m, 1'b0, none));   // middle column zero
    for (int i = 0; i < 9; i++) m[i] = 32'hff000000;     // all columns equal
    pending_words.push_back(table_row(m, 1'b0, none));
    for (int i = 0; i < 9; i++) m[i] = ((i % 3) == 0) ? 32'h0 : 32'h00000003;
    pending_words.push_back(table_row(m, 1'b0, none));   // first column zero
    for (int i = 0; i < 9; i++) m[i] = $urandom;
    for (int i = 0; i < 3; i++) m[i*3+2] = '0;
    pending_words.push_back(table_row(m, 1'b0, none));   // last column zero
    m = '0;
    m[0] = 32'h00000001; m[3] = 32'h00000001; m[6] = 32'h00000001;
    m[1] = 32'h00000002; m[4] = 32'h00000002; m[7] = 32'h00000002;
    m[2] = 32'h7fffffff; m[5] = 32'h80000000; m[8] = 32'h00000000;
    pending_words.push_back(table_row(m, 1'b0, none));

    // random part, four idling phases, hold-off during the first
    for (int phase = 0; phase < 4; phase++) begin
      while (pending_words.size() != 0) @(posedge clk_i);
      case (phase)
        0: begin idle_in_pct = 0;  stall_out_pct = 0;  end
        1: begin idle_in_pct = 72; stall_out_pct = 0;  end
        2: begin idle_in_pct = 0;  stall_out_pct = 72; end
        default: begin idle_in_pct = 9; stall_out_pct = 9; end
      endcase
      for (int n = 0; n < 335; n++) begin
        pending_words.push_back(table_row(random_matrix($urandom_range(0, 6)), 1'b0, none));
        if (phase == 0 && n == 60) begin
          while (pending_words.size() > 20) @(posedge clk_i);
          hold_request = 1'b1;
        end
      end
    end

    while (pending_words.size() != 0 || in_ch.valid || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (TOP_LAT + 20) @(posedge clk_i);

    $display("covered %0d matrices in, %0d out, %0d with a zero column", words_in, words_out,
             degen_seen);
    $display("idling phases: none, sender, receiver, both; one long receiver hold-off");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
